// File: sv/gfau_pkg.sv
// Shared types, codes and GF(2^12) arithmetic for the GF(2^12) arithmetic unit.
// Holds the field multiplier function and the inversion step table.
// No dependencies.
package gfau_pkg;

  localparam int unsigned FIELD_W   = 12;
  localparam int unsigned PROD_W    = 2 * FIELD_W - 1;
  localparam int unsigned INV_STEPS = 16;
  localparam int unsigned STEP_W    = $clog2(INV_STEPS);

  localparam int unsigned S_TDATA_W = 32;  // action, operand_a, operand_b, zero fill
  localparam int unsigned S_TUSER_W = 1;   // first_term
  localparam int unsigned M_TDATA_W = 16;  // value, zero fill

  typedef logic [FIELD_W-1:0] elem_t;

  typedef enum logic [1:0] {
    ACT_MUL = 2'd0,
    ACT_SQR = 2'd1,
    ACT_INV = 2'd2,
    ACT_MAC = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    SRC_A  = 3'd0,
    SRC_B  = 3'd1,
    SRC_R  = 3'd2,
    SRC_T2 = 3'd3,
    SRC_T4 = 3'd4
  } src_e;

  // One pass of the shared multiplier.
  typedef struct packed {
    src_e x_sel;
    src_e y_sel;
    logic wr_r;
    logic wr_t2;
    logic wr_t4;
    logic mac;
  } op_cmd_t;

  // Controller to datapath.
  typedef struct packed {
    logic    load;      // capture a new word's operands
    logic    fire;      // commit this step's multiplier result
    logic    load_out;  // move result into the output register
    op_cmd_t op;
  } ctl_t;

  // Carry-less 12x12 product reduced modulo x^12 + x^3 + 1.
  function automatic elem_t gf_mul(elem_t a, elem_t b);
    logic [PROD_W-1:0]    p;
    logic [FIELD_W-2:0]   hi;
    logic [FIELD_W+1:0]   f;
    elem_t                g;
    p = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      p = p ^ (({{(FIELD_W-1){1'b0}}, a} << i) & {PROD_W{b[i]}});
    end
    hi = p[PROD_W-1:FIELD_W];
    // x^12 = x^3 + 1, applied once to the high half ...
    f = {3'b000, hi} ^ {hi, 3'b000};
    // ... and once more to the two bits that spill past x^11
    g = f[FIELD_W-1:0] ^ {{(FIELD_W-2){1'b0}}, f[FIELD_W+1:FIELD_W]}
                       ^ {{(FIELD_W-5){1'b0}}, f[FIELD_W+1:FIELD_W], 3'b000};
    return p[FIELD_W-1:0] ^ g;
  endfunction

  function automatic op_cmd_t mk_cmd(src_e x, src_e y, logic w_r, logic w_t2,
                                     logic w_t4, logic m);
    op_cmd_t c;
    c.x_sel = x;
    c.y_sel = y;
    c.wr_r  = w_r;
    c.wr_t2 = w_t2;
    c.wr_t4 = w_t4;
    c.mac   = m;
    return c;
  endfunction

  // Step table: a^4094 through eleven squarings and five multiplications.
  function automatic op_cmd_t step_cmd(action_e act, logic [STEP_W-1:0] step);
    op_cmd_t c;
    c = mk_cmd(SRC_A, SRC_B, 1'b1, 1'b0, 1'b0, 1'b0);
    unique case (act)
      ACT_MUL: c = mk_cmd(SRC_A, SRC_B, 1'b1, 1'b0, 1'b0, 1'b0);
      ACT_SQR: c = mk_cmd(SRC_A, SRC_A, 1'b1, 1'b0, 1'b0, 1'b0);
      ACT_MAC: c = mk_cmd(SRC_A, SRC_B, 1'b1, 1'b0, 1'b0, 1'b1);
      ACT_INV: begin
        unique case (step)
          4'd0:  c = mk_cmd(SRC_A,  SRC_A,  1'b1, 1'b0, 1'b0, 1'b0); // a^2
          4'd1:  c = mk_cmd(SRC_R,  SRC_A,  1'b0, 1'b1, 1'b0, 1'b0); // t2 = a^3
          4'd2:  c = mk_cmd(SRC_T2, SRC_T2, 1'b1, 1'b0, 1'b0, 1'b0);
          4'd4:  c = mk_cmd(SRC_R,  SRC_T2, 1'b1, 1'b0, 1'b1, 1'b0); // t4 = a^15
          4'd9:  c = mk_cmd(SRC_R,  SRC_T4, 1'b1, 1'b0, 1'b0, 1'b0); // a^255
          4'd12: c = mk_cmd(SRC_R,  SRC_T2, 1'b1, 1'b0, 1'b0, 1'b0); // a^1023
          4'd14: c = mk_cmd(SRC_R,  SRC_A,  1'b1, 1'b0, 1'b0, 1'b0); // a^2047
          default: c = mk_cmd(SRC_R, SRC_R, 1'b1, 1'b0, 1'b0, 1'b0); // square r
        endcase
      end
      default: c = mk_cmd(SRC_A, SRC_B, 1'b1, 1'b0, 1'b0, 1'b0);
    endcase
    return c;
  endfunction

endpackage

// File: sv/gfau_ctrl.sv
// Sequencer for the GF(2^12) arithmetic unit: handshakes and step counting.
// Depends on gfau_pkg.
module gfau_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  gfau_pkg::action_e           action_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output gfau_pkg::ctl_t              ctl_o
);
  import gfau_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic              state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  action_e           action_q, action_d;
  logic              out_valid_q, out_valid_d;
  logic              accept, last, fire;

  assign s_ready_o = (state_q == S_IDLE);
  assign accept    = s_valid_i & s_ready_o;
  assign last      = (action_q != ACT_INV) || (step_q == STEP_W'(INV_STEPS - 1));
  // last step commits only into a free output register
  assign fire      = (state_q == S_BUSY) && (!last || !out_valid_q || m_ready_i);

  always_comb begin
    ctl_o.load     = accept;
    ctl_o.fire     = fire;
    ctl_o.load_out = fire & last;
    ctl_o.op       = step_cmd(action_q, step_q);
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    action_d    = action_q;
    out_valid_d = out_valid_q;
    if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire && last) begin
      out_valid_d = 1'b1;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d  = S_BUSY;
          step_d   = '0;
          action_d = action_i;
        end
      end
      S_BUSY: begin
        if (fire) begin
          if (last) begin
            state_d = S_IDLE;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      action_q    <= ACT_MUL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      action_q    <= action_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

// File: sv/gfau_dp.sv
// Datapath for the GF(2^12) arithmetic unit: operand and working registers,
// one shared field multiplier, accumulator and output register. Uses gfau_pkg.
module gfau_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gfau_pkg::ctl_t       ctl_i,
  input  gfau_pkg::elem_t      operand_a_i,
  input  gfau_pkg::elem_t      operand_b_i,
  input  logic                 first_term_i,
  output gfau_pkg::elem_t      value_o
);
  import gfau_pkg::*;

  elem_t a_q, b_q, r_q, t2_q, t4_q, out_q;
  logic  first_q;
  elem_t acc_q, acc_d;
  elem_t x, y, prod, res;

  function automatic elem_t pick(src_e s, elem_t a, elem_t b, elem_t r,
                                 elem_t t2, elem_t t4);
    elem_t v;
    v = a;
    unique case (s)
      SRC_A:   v = a;
      SRC_B:   v = b;
      SRC_R:   v = r;
      SRC_T2:  v = t2;
      SRC_T4:  v = t4;
      default: v = a;
    endcase
    return v;
  endfunction

  assign x    = pick(ctl_i.op.x_sel, a_q, b_q, r_q, t2_q, t4_q);
  assign y    = pick(ctl_i.op.y_sel, a_q, b_q, r_q, t2_q, t4_q);
  assign prod = gf_mul(x, y);
  // a new sum starts from zero instead of the kept accumulator
  assign res  = ctl_i.op.mac ? (prod ^ (first_q ? '0 : acc_q)) : prod;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.fire && ctl_i.op.mac) begin
      acc_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      a_q     <= operand_a_i;
      b_q     <= operand_b_i;
      first_q <= first_term_i;
    end
    if (ctl_i.fire && ctl_i.op.wr_r) begin
      r_q <= res;
    end
    if (ctl_i.fire && ctl_i.op.wr_t2) begin
      t2_q <= res;
    end
    if (ctl_i.fire && ctl_i.op.wr_t4) begin
      t4_q <= res;
    end
    if (ctl_i.load_out) begin
      out_q <= res;
    end
  end

  assign value_o = out_q;

endmodule

// File: sv/gf4096_arith_unit_top.sv
// Multiply, square and multiply-accumulate make one multiplier pass after acceptance;
//   inverse makes 16 multiplier passes before its result word is raised.
// One word is taken at a time: no new word is accepted until the last one's result is
//   committed, since the chain runs through the single shared GF(2^12) multiplier.
// Reset: rst_ni clears the sequencer, output valid and the accumulator at once.
// Top level; instantiates gfau_ctrl and gfau_dp, uses gfau_pkg.
module gf4096_arith_unit_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave side
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [1:0] action, [13:2] operand_a, [25:14] operand_b, [31:26] zero
  input  logic [gfau_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // [0] first_term
  input  logic [gfau_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  // master side
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [11:0] value, [15:12] zero
  output logic [gfau_pkg::M_TDATA_W-1:0]   m_axis_tdata_o
);
  import gfau_pkg::*;

  ctl_t  ctl;
  elem_t value;

  // Sequencer: takes one word at a time, steps the inversion chain, and
  // holds the final step while the output register is still occupied.
  gfau_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .action_i  (action_e'(s_axis_tdata_i[1:0])),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .ctl_o     (ctl)
  );

  // Datapath: operands are captured on acceptance; each step pushes one
  // pass through the shared multiplier into the working registers.
  gfau_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .operand_a_i  (s_axis_tdata_i[13:2]),
    .operand_b_i  (s_axis_tdata_i[25:14]),
    .first_term_i (s_axis_tuser_i[0]),
    .value_o      (value)
  );

  // Zero-fill the result word to whole bytes.
  assign m_axis_tdata_o = {{(M_TDATA_W - FIELD_W){1'b0}}, value};

endmodule

// File: sv/gfau_chk.sv
// Port-level checker for the GF(2^12) arithmetic unit, bound to the top level.
// Uses gfau_pkg for port widths.
module gfau_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [gfau_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  input logic [gfau_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [gfau_pkg::M_TDATA_W-1:0]   m_axis_tdata_o
);
  import gfau_pkg::*;

  // stalled result word stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  // stalled result word keeps its value
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // one word in flight: no new word right after acceptance
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second word taken while busy");

  // a result cannot appear in the cycle right after acceptance
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
    else $error("result word appeared too early");

  // reset leaves no result on the output
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

endmodule

bind gf4096_arith_unit_top gfau_chk u_gfau_chk (.*);
